// File: src/updsn_pkg.sv
// shared types and constants of the url path dot segment normalizer
`default_nettype none
package updsn_pkg;

    localparam logic [7:0] SLASH_CHAR = 8'h2f;
    localparam logic [7:0] DOT_CHAR   = 8'h2e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEP2,
        ST_ENDSEG,
        ST_POP,
        ST_SLASH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take;
        logic write_held;
        logic end_seg;
        logic pop_load;
        logic show_slash;
        logic emit_adv;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic needs_sep;
        logic will_pop;
        logic wp_zero;
        logic at_end;
    } status_t;

endpackage
`default_nettype wire

// File: src/url_path_dot_segment_normalizer.sv
// top level of the url path dot segment normalizer
//
// input channel (s_valid / s_ready): one path byte per word in s_in_char, s_in_last
// on the final word, s_end_only for a word that only ends the path (byte ignored).
// output channel (m_valid / m_ready): after the final input word the block sends
// "/" and then the kept segments joined by "/", one byte per word, with m_out_last
// on the final byte and m_overflow set on every word if bytes were dropped.
// throughput: one input word per cycle while idle; the first byte of a segment that
// needs a separator adds ST_SEP2 (one char store write port), a ".." that pops
// the segment stack adds ST_POP (registered stack read), and a final word that
// carries a byte adds ST_ENDSEG to close the segment.
// output: the "/" word is sent from ST_SLASH, after ST_SEP2, ST_ENDSEG, ST_POP
// as needed; the stored bytes then follow one per cycle from the registered char
// store read, which keeps the next byte ready while the receiver stalls.
// no input is taken while a path is being sent; a stalled receiver simply holds
// the current word. reset (aresetn low, synchronous) empties the path state;
// the stores need no clearing since only written entries are read.
`default_nettype none
module url_path_dot_segment_normalizer #(
    parameter int MAX_PATH_BYTES = 63,
    parameter int MAX_SEGMENTS   = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_char,
    input  wire logic       s_in_last,
    input  wire logic       s_end_only,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_char,
    output logic            m_out_last,
    output logic            m_overflow
);

    updsn_pkg::cmd_t    cmd;
    updsn_pkg::status_t status;

    updsn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .in_char  (s_in_char),
        .in_last  (s_in_last),
        .end_only (s_end_only),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .status   (status)
    );

    updsn_datapath #(
        .MAX_PATH_BYTES (MAX_PATH_BYTES),
        .MAX_SEGMENTS   (MAX_SEGMENTS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .in_char  (s_in_char),
        .out_char (m_out_char),
        .out_last (m_out_last),
        .overflow (m_overflow)
    );

endmodule
`default_nettype wire

// File: src/updsn_datapath.sv
// character store, segment stack and path bookkeeping of the normalizer
`default_nettype none
module updsn_datapath #(
    parameter int MAX_PATH_BYTES = 63,
    parameter int MAX_SEGMENTS   = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire updsn_pkg::cmd_t    cmd,
    output updsn_pkg::status_t      status,
    input  wire logic [7:0]         in_char,
    output logic [7:0]              out_char,
    output logic                    out_last,
    output logic                    overflow
);

    localparam int PW  = $clog2(MAX_PATH_BYTES + 1);
    localparam int AW  = $clog2(MAX_PATH_BYTES);
    localparam int SCW = $clog2(MAX_SEGMENTS + 1);
    localparam int SIW = $clog2(MAX_SEGMENTS);
    localparam logic [PW:0]    PATH_LIMIT = (PW+1)'(MAX_PATH_BYTES);
    localparam logic [SCW-1:0] SEG_LIMIT  = SCW'(MAX_SEGMENTS);

    logic [7:0]    char_mem [MAX_PATH_BYTES];
    logic [AW-1:0] seg_mem  [MAX_SEGMENTS];

    logic [7:0]     char_rd_reg;
    logic [AW-1:0]  seg_rd_reg;
    logic [7:0]     held_reg, held_next;
    logic [PW-1:0]  wp_reg, wp_next;
    logic [PW-1:0]  cs_reg, cs_next;
    logic [SCW-1:0] count_reg, count_next;
    logic           ovf_reg, ovf_next;
    logic [1:0]     tok_len_reg, tok_len_next;
    logic           tok_dots_reg, tok_dots_next;
    logic [AW-1:0]  idx_reg, idx_next;

    logic           tok_empty, is_dot, is_dotdot, has_seg;
    logic           first_fits, later_fits, wp_zero, at_end;
    logic           char_wr_en, seg_wr_en, seg_rd_en;
    logic [7:0]     char_wr_data;
    logic [AW-1:0]  char_rd_addr;
    logic [SIW-1:0] seg_rd_addr;

    assign tok_empty  = (tok_len_reg == 2'd0);
    assign is_dot     = tok_dots_reg && (tok_len_reg == 2'd1);
    assign is_dotdot  = tok_dots_reg && (tok_len_reg == 2'd2);
    assign has_seg    = (count_reg != '0);
    assign first_fits = (({1'b0, wp_reg} + (has_seg ? (PW+1)'(2) : (PW+1)'(1))) <= PATH_LIMIT);
    assign later_fits = (wp_reg < PW'(MAX_PATH_BYTES));
    assign wp_zero    = (wp_reg == '0);
    assign at_end     = ((PW'(idx_reg) + PW'(1)) == wp_reg);

    assign status.needs_sep = tok_empty && has_seg && first_fits;
    assign status.will_pop  = is_dotdot && has_seg;
    assign status.wp_zero   = wp_zero;
    assign status.at_end    = at_end;

    assign char_rd_addr = (cmd.emit_adv && !at_end) ? idx_reg + AW'(1) : idx_reg;
    assign seg_rd_addr  = SIW'(count_reg - SCW'(1));
    assign seg_rd_en    = cmd.end_seg && is_dotdot && has_seg;

    assign out_char = cmd.show_slash ? updsn_pkg::SLASH_CHAR : char_rd_reg;
    assign out_last = cmd.show_slash ? wp_zero : at_end;
    assign overflow = ovf_reg;

    always_comb begin
        wp_next       = wp_reg;
        cs_next       = cs_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        tok_len_next  = tok_len_reg;
        tok_dots_next = tok_dots_reg;
        held_next     = held_reg;
        idx_next      = idx_reg;
        char_wr_en    = 1'b0;
        char_wr_data  = in_char;
        seg_wr_en     = 1'b0;

        if (cmd.clear) begin
            wp_next       = '0;
            cs_next       = '0;
            count_next    = '0;
            ovf_next      = 1'b0;
            tok_len_next  = 2'd0;
            tok_dots_next = 1'b1;
            idx_next      = '0;
        end else if (cmd.take) begin
            held_next = in_char;
            if (tok_empty) begin
                if (first_fits) begin
                    char_wr_en   = 1'b1;
                    char_wr_data = has_seg ? updsn_pkg::SLASH_CHAR : in_char;
                    wp_next      = wp_reg + PW'(1);
                end else begin
                    ovf_next = 1'b1;
                end
            end else if (later_fits) begin
                char_wr_en = 1'b1;
                wp_next    = wp_reg + PW'(1);
            end else begin
                ovf_next = 1'b1;
            end
            tok_dots_next = tok_dots_reg && (in_char == updsn_pkg::DOT_CHAR);
            tok_len_next  = (tok_len_reg == 2'd3) ? 2'd3 : tok_len_reg + 2'd1;
        end else if (cmd.write_held) begin
            char_wr_en   = 1'b1;
            char_wr_data = held_reg;
            wp_next      = wp_reg + PW'(1);
        end else if (cmd.end_seg) begin
            tok_len_next  = 2'd0;
            tok_dots_next = 1'b1;
            if (tok_empty || is_dot) begin
                wp_next = cs_reg;
            end else if (is_dotdot) begin
                wp_next = cs_reg;
                if (has_seg) begin
                    count_next = count_reg - SCW'(1);
                end
            end else if (wp_reg == cs_reg) begin
                wp_next = wp_reg;
            end else if (count_reg < SEG_LIMIT) begin
                seg_wr_en  = 1'b1;
                count_next = count_reg + SCW'(1);
                cs_next    = wp_reg;
            end else begin
                wp_next  = cs_reg;
                ovf_next = 1'b1;
            end
        end else if (cmd.pop_load) begin
            cs_next = PW'(seg_rd_reg);
            wp_next = PW'(seg_rd_reg);
        end

        if (!cmd.clear && cmd.emit_adv) begin
            idx_next = idx_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            cs_reg       <= '0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            tok_len_reg  <= 2'd0;
            tok_dots_reg <= 1'b1;
            idx_reg      <= '0;
        end else begin
            wp_reg       <= wp_next;
            cs_reg       <= cs_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            tok_len_reg  <= tok_len_next;
            tok_dots_reg <= tok_dots_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg <= held_next;
        if (char_wr_en) begin
            char_mem[wp_reg[AW-1:0]] <= char_wr_data;
        end
        char_rd_reg <= char_mem[char_rd_addr];
        if (seg_wr_en) begin
            seg_mem[count_reg[SIW-1:0]] <= cs_reg[AW-1:0];
        end
        if (seg_rd_en) begin
            seg_rd_reg <= seg_mem[seg_rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: src/updsn_ctrl.sv
// controller state machine of the url path dot segment normalizer
`default_nettype none
module updsn_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         in_char,
    input  wire logic               in_last,
    input  wire logic               end_only,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output updsn_pkg::cmd_t         cmd,
    input  wire updsn_pkg::status_t status
);

    updsn_pkg::state_t state_reg, state_next;
    logic              last_reg, last_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= updsn_pkg::ST_IDLE;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;

        unique case (state_reg)
            updsn_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    last_next = in_last;
                    if (end_only) begin
                        if (in_last) begin
                            cmd.end_seg = 1'b1;
                            state_next  = status.will_pop ? updsn_pkg::ST_POP
                                                          : updsn_pkg::ST_SLASH;
                        end
                    end else if (in_char == updsn_pkg::SLASH_CHAR) begin
                        cmd.end_seg = 1'b1;
                        if (status.will_pop) begin
                            state_next = updsn_pkg::ST_POP;
                        end else if (in_last) begin
                            state_next = updsn_pkg::ST_SLASH;
                        end
                    end else begin
                        cmd.take = 1'b1;
                        if (status.needs_sep) begin
                            state_next = updsn_pkg::ST_SEP2;
                        end else if (in_last) begin
                            state_next = updsn_pkg::ST_ENDSEG;
                        end
                    end
                end
            end
            updsn_pkg::ST_SEP2: begin
                cmd.write_held = 1'b1;
                state_next = last_reg ? updsn_pkg::ST_ENDSEG : updsn_pkg::ST_IDLE;
            end
            updsn_pkg::ST_ENDSEG: begin
                cmd.end_seg = 1'b1;
                state_next  = status.will_pop ? updsn_pkg::ST_POP : updsn_pkg::ST_SLASH;
            end
            updsn_pkg::ST_POP: begin
                cmd.pop_load = 1'b1;
                state_next   = last_reg ? updsn_pkg::ST_SLASH : updsn_pkg::ST_IDLE;
            end
            updsn_pkg::ST_SLASH: begin
                m_valid        = 1'b1;
                cmd.show_slash = 1'b1;
                if (m_ready) begin
                    if (status.wp_zero) begin
                        cmd.clear  = 1'b1;
                        state_next = updsn_pkg::ST_IDLE;
                    end else begin
                        state_next = updsn_pkg::ST_EMIT;
                    end
                end
            end
            updsn_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.emit_adv = 1'b1;
                    if (status.at_end) begin
                        cmd.clear  = 1'b1;
                        state_next = updsn_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = updsn_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: bench/path_normalizer_checker.sv
// checker for the url path dot segment normalizer: predicts each path and compares output words
`timescale 1ns / 1ps
module path_normalizer_checker (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic [7:0] s_in_char,
    input  wire logic       s_in_last,
    input  wire logic       s_end_only,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic [7:0] m_out_char,
    input  wire logic       m_out_last,
    input  wire logic       m_overflow,
    output int              error_count,
    output int              pending_count
);

    localparam int PATH_BYTES = 63;
    localparam int SEG_LIMIT  = 32;

    typedef struct packed {
        logic [7:0] ch;
        logic       tail;
        logic       ovf;
    } path_byte_t;

    logic [7:0] kept_text [PATH_BYTES];
    int         seg_start [SEG_LIMIT];
    int         seg_total;
    int         fill_pos;
    int         open_start;
    int         tok_len;
    bit         tok_all_dots;
    bit         dropped;
    path_byte_t expected_bytes [$];

    function void start_new_path();
        seg_total    = 0;
        fill_pos     = 0;
        open_start   = 0;
        tok_len      = 0;
        tok_all_dots = 1'b1;
        dropped      = 1'b0;
    endfunction

    function void close_segment();
        bit one_dot;
        bit two_dots;
        one_dot  = tok_all_dots && tok_len == 1;
        two_dots = tok_all_dots && tok_len == 2;
        if (tok_len == 0 || one_dot) begin
            fill_pos = open_start;
        end else if (two_dots) begin
            fill_pos = open_start;
            if (seg_total > 0) begin
                seg_total--;
                open_start = seg_start[seg_total];
                fill_pos   = open_start;
            end
        end else if (fill_pos != open_start) begin
            if (seg_total < SEG_LIMIT) begin
                seg_start[seg_total] = open_start;
                seg_total++;
                open_start = fill_pos;
            end else begin
                fill_pos = open_start;
                dropped  = 1'b1;
            end
        end
        tok_len      = 0;
        tok_all_dots = 1'b1;
    endfunction

    function void absorb_word(input logic [7:0] c, input logic last, input logic no_byte);
        int         need;
        path_byte_t entry;
        if (!no_byte) begin
            if (c == updsn_pkg::SLASH_CHAR) begin
                close_segment();
            end else begin
                if (tok_len == 0) begin
                    need = (seg_total > 0) ? 2 : 1;
                    if (fill_pos + need <= PATH_BYTES) begin
                        if (seg_total > 0) begin
                            kept_text[fill_pos] = updsn_pkg::SLASH_CHAR;
                            fill_pos++;
                        end
                        kept_text[fill_pos] = c;
                        fill_pos++;
                    end else begin
                        dropped = 1'b1;
                    end
                end else if (fill_pos < PATH_BYTES) begin
                    kept_text[fill_pos] = c;
                    fill_pos++;
                end else begin
                    dropped = 1'b1;
                end
                if (c != updsn_pkg::DOT_CHAR) tok_all_dots = 1'b0;
                if (tok_len < 3) tok_len++;
            end
        end
        if (last) begin
            close_segment();
            entry.ch   = updsn_pkg::SLASH_CHAR;
            entry.tail = (fill_pos == 0);
            entry.ovf  = dropped;
            expected_bytes = {expected_bytes, entry};
            for (int i = 0; i < fill_pos; i++) begin
                entry.ch   = kept_text[i];
                entry.tail = (i + 1 == fill_pos);
                entry.ovf  = dropped;
                expected_bytes = {expected_bytes, entry};
            end
            start_new_path();
        end
    endfunction

    always @(posedge aclk) begin
        path_byte_t want;
        if (!aresetn) begin
            start_new_path();
            expected_bytes.delete();
        end else begin
            if (s_valid && s_ready) absorb_word(s_in_char, s_in_last, s_end_only);
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected word: char %h last %b overflow %b",
                                 m_out_char, m_out_last, m_overflow);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_out_char !== want.ch || m_out_last !== want.tail ||
                        m_overflow !== want.ovf) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: expected char %h last %b overflow %b, got %h %b %b",
                                     want.ch, want.tail, want.ovf,
                                     m_out_char, m_out_last, m_overflow);
                    end
                end
            end
        end
        pending_count = expected_bytes.size();
    end

endmodule

// File: bench/testbench.sv
// top of the url path dot segment normalizer bench: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module testbench;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;

    typedef logic [7:0] path_text_t [$];

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_char;
    logic       s_in_last;
    logic       s_end_only;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_char;
    logic       m_out_last;
    logic       m_overflow;
    int         error_count;
    int         pending_count;

    int src_idle_pct;
    int sink_idle_pct;
    bit hold_request;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int words_sent;
    int cycle_count;

    url_path_dot_segment_normalizer dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_char  (s_in_char),
        .s_in_last  (s_in_last),
        .s_end_only (s_end_only),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_out_last (m_out_last),
        .m_overflow (m_overflow)
    );

    path_normalizer_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_char     (s_in_char),
        .s_in_last     (s_in_last),
        .s_end_only    (s_end_only),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_out_last    (m_out_last),
        .m_overflow    (m_overflow),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    task automatic put_word(input logic [7:0] c, input logic last, input logic no_byte);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_in_char  <= c;
        s_in_last  <= last;
        s_end_only <= no_byte;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_path(input path_text_t text, input bit close_bare, input bit sprinkle);
        bit bare;
        bare = close_bare || text.size() == 0;
        for (int i = 0; i < text.size(); i++) begin
            if (sprinkle && $urandom_range(0, 14) == 0)
                put_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            put_word(text[i], !bare && i == text.size() - 1, 1'b0);
            words_sent++;
        end
        if (bare) begin
            put_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            words_sent++;
        end
    endtask

    function automatic path_text_t text_of(input string s);
        path_text_t q;
        for (int i = 0; i < s.len(); i++) q = {q, s[i]};
        return q;
    endfunction

    task automatic send_random_path(input bit long_path);
        path_text_t q;
        int         seg_n;
        int         name_len;
        logic [7:0] c;
        if (!long_path && $urandom_range(0, 6) == 0) begin
            // noise: loose mix of slashes, dots and raw bytes
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(0, 2))
                    0: c = updsn_pkg::SLASH_CHAR;
                    1: c = updsn_pkg::DOT_CHAR;
                    default: c = 8'($urandom_range(0, 255));
                endcase
                q = {q, c};
            end
        end else begin
            if ($urandom_range(0, 1) == 1) q = {q, updsn_pkg::SLASH_CHAR};
            seg_n = long_path ? $urandom_range(30, 40) : $urandom_range(0, 6);
            for (int s = 0; s < seg_n; s++) begin
                if (s > 0) q = {q, updsn_pkg::SLASH_CHAR};
                case ($urandom_range(0, 9))
                    0: ;
                    1, 2: q = {q, updsn_pkg::DOT_CHAR};
                    3, 4: begin
                        q = {q, updsn_pkg::DOT_CHAR};
                        q = {q, updsn_pkg::DOT_CHAR};
                    end
                    default: begin
                        name_len = $urandom_range(1, long_path ? 2 : 5);
                        repeat (name_len) begin
                            case ($urandom_range(0, 3))
                                0: c = updsn_pkg::DOT_CHAR;
                                1, 2: c = 8'h61 + 8'($urandom_range(0, 25));
                                default: begin
                                    c = 8'($urandom_range(0, 255));
                                    if (c == updsn_pkg::SLASH_CHAR) c = 8'h7e;
                                end
                            endcase
                            q = {q, c};
                        end
                    end
                endcase
            end
            if ($urandom_range(0, 3) == 0) q = {q, updsn_pkg::SLASH_CHAR};
        end
        send_path(q, $urandom_range(0, 3) == 0, 1'b1);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL url_path_dot_segment_normalizer");
        $finish;
    end

    initial begin
        s_valid       = 1'b0;
        s_in_char     = 8'h00;
        s_in_last     = 1'b0;
        s_end_only    = 1'b0;
        aresetn       = 1'b0;
        src_idle_pct  = 19;
        sink_idle_pct = 85;
        hold_request  = 1'b0;
        words_sent    = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed paths
        send_path(text_of(""), 1'b1, 1'b0);
        put_word(8'h41, 1'b0, 1'b1);
        send_path(text_of("/"), 1'b0, 1'b0);
        send_path(text_of("../a/./b/.."), 1'b0, 1'b0);
        send_path('{8'hff, updsn_pkg::SLASH_CHAR, updsn_pkg::SLASH_CHAR, 8'h00}, 1'b1, 1'b0);
        send_path(text_of("..."), 1'b0, 1'b0);

        send_random_path(1'b1);
        while (words_sent < 95) send_random_path($urandom_range(0, 11) == 0);

        src_idle_pct  = 85;
        sink_idle_pct = 19;
        while (words_sent < 165) send_random_path($urandom_range(0, 11) == 0);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_request  = 1'b1;
        while (words_sent < 235) send_random_path($urandom_range(0, 11) == 0);

        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (error_count == 0 && pending_count == 0)
            $display("PASS url_path_dot_segment_normalizer");
        else
            $display("FAIL url_path_dot_segment_normalizer");
        $finish;
    end

endmodule

// File: files.f
src/updsn_pkg.sv
src/updsn_datapath.sv
src/updsn_ctrl.sv
src/url_path_dot_segment_normalizer.sv
bench/path_normalizer_checker.sv
bench/testbench.sv
